FILE: rtl/clm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clm_pkg
// Types and codes shared by the cursor linked list manager and its checker.
// ----------------------------------------------------------------------------
package clm_pkg;

  localparam int unsigned AcctW   = 31;
  localparam int unsigned OpW     = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned TotalW  = 5;

  localparam logic [OpW-1:0] OP_APPEND  = 3'd0;
  localparam logic [OpW-1:0] OP_DELETE  = 3'd1;
  localparam logic [OpW-1:0] OP_BACK    = 3'd2;
  localparam logic [OpW-1:0] OP_FORWARD = 3'd3;
  localparam logic [OpW-1:0] OP_PEEK    = 3'd4;

  localparam logic [StatusW-1:0] STATUS_DONE  = 2'd0;
  localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [AcctW-1:0] account;
  } clm_cmd_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               cursor_valid;
    logic [AcctW-1:0]   cursor_account;
    logic [TotalW-1:0]  entry_total;
  } clm_result_t;

endpackage
`default_nettype wire

FILE: rtl/cursor_linked_list_manager_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cursor_linked_list_manager_unit
// Doubly linked list of account numbers with a cursor, held in a slot pool.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; exactly one result
// follows on result_o, marked by a one-cycle done_o pulse that the receiver
// must take as it comes. Append, peek, a move that stops at the head or tail,
// a delete of the only entry and commands that report empty or full pass
// through the execute state alone; a delete that leaves the cursor on an
// entry and a move that shifts the cursor also pass through the fetch state,
// because the cursor's links and then the new cursor's account are each read
// from single-port memories with registered read data. Only the neighbours'
// links of a deleted entry are written.
module cursor_linked_list_manager_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start,
  output logic                 busy,
  input  clm_pkg::clm_cmd_t    cmd_i,
  output logic                 done_o,
  output clm_pkg::clm_result_t result_o
);

  import clm_pkg::*;

  localparam int unsigned SW = $clog2(CAPACITY);
  localparam int unsigned IW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] NONE = IW'(CAPACITY);
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_FETCH = 2'd2;

  // slot memories
  logic [AcctW-1:0] acct_mem [CAPACITY];
  logic [SW-1:0]    next_mem [CAPACITY];
  logic [SW-1:0]    prev_mem [CAPACITY];

  logic [1:0]          state_q, state_d;
  clm_cmd_t            cmd_q;
  logic [IW-1:0]       head_q, head_d, tail_q, tail_d, cursor_q, cursor_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CAPACITY-1:0] in_use_q, in_use_d;
  logic [SW-1:0]       free_q, free_d;
  logic [AcctW-1:0]    cur_acct_q, cur_acct_d;
  logic [SW-1:0]       prev_rd_q, next_rd_q;
  logic [AcctW-1:0]    acct_rd_q;
  logic                done_q, done_d;
  clm_result_t         result_q, result_d;
  logic [StatusW-1:0]  status_d;

  logic             accept;
  logic             acct_we, next_we, prev_we, acct_re;
  logic [SW-1:0]    acct_waddr, next_waddr, prev_waddr, acct_raddr;
  logic [SW-1:0]    next_wdata, prev_wdata;
  logic [IW-1:0]    prior, after, dest;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign done_o   = done_q;
  assign result_o = result_q;

  // Lowest free slot, registered for the next append
  always_comb begin
    free_d = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_d = SW'(i);
      end
    end
  end

  // Head has no predecessor and tail no successor, whatever the link memory holds
  assign prior = (cursor_q == head_q) ? NONE : IW'(prev_rd_q);
  assign after = (cursor_q == tail_q) ? NONE : IW'(next_rd_q);
  assign dest  = (cmd_q.opcode == OP_FORWARD) ? after : prior;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    cursor_d   = cursor_q;
    count_d    = count_q;
    in_use_d   = in_use_q;
    cur_acct_d = cur_acct_q;
    done_d     = 1'b0;
    status_d   = STATUS_DONE;
    acct_we    = 1'b0;
    next_we    = 1'b0;
    prev_we    = 1'b0;
    acct_re    = 1'b0;
    acct_waddr = free_q;
    next_waddr = tail_q[SW-1:0];
    prev_waddr = free_q;
    next_wdata = free_q;
    prev_wdata = tail_q[SW-1:0];
    acct_raddr = cursor_q[SW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        unique case (cmd_q.opcode)
          OP_APPEND: begin
            if (count_q == FULL_COUNT) begin
              status_d = STATUS_FULL;
            end else begin
              acct_we = 1'b1;
              prev_we = 1'b1;
              if (tail_q != NONE) begin
                next_we = 1'b1;
              end else begin
                head_d = IW'(free_q);
              end
              tail_d           = IW'(free_q);
              cursor_d         = IW'(free_q);
              in_use_d[free_q] = 1'b1;
              count_d          = count_q + CW'(1);
              cur_acct_d       = cmd_q.account;
            end
          end
          OP_DELETE: begin
            if (cursor_q == NONE) begin
              status_d = STATUS_EMPTY;
            end else begin
              if (prior != NONE) begin
                next_we    = 1'b1;
                next_waddr = prior[SW-1:0];
                next_wdata = after[SW-1:0];
              end else begin
                head_d = after;
              end
              if (after != NONE) begin
                prev_we    = 1'b1;
                prev_waddr = after[SW-1:0];
                prev_wdata = prior[SW-1:0];
              end else begin
                tail_d = prior;
              end
              cursor_d                    = (after != NONE) ? after : prior;
              in_use_d[cursor_q[SW-1:0]]  = 1'b0;
              count_d                     = count_q - CW'(1);
              if (cursor_d == NONE) begin
                cur_acct_d = '0;
              end else begin
                // fetch the new cursor's account before reporting
                acct_re    = 1'b1;
                acct_raddr = cursor_d[SW-1:0];
                done_d     = 1'b0;
                state_d    = ST_FETCH;
              end
            end
          end
          OP_BACK, OP_FORWARD: begin
            if (cursor_q == NONE) begin
              status_d = STATUS_EMPTY;
            end else if (dest != NONE) begin
              cursor_d   = dest;
              acct_re    = 1'b1;
              acct_raddr = dest[SW-1:0];
              done_d     = 1'b0;
              state_d    = ST_FETCH;
            end
          end
          default: begin
            // peek and unused codes: report only
          end
        endcase
      end
      ST_FETCH: begin
        cur_acct_d = acct_rd_q;
        done_d     = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    result_d                = result_q;
    if (done_d) begin
      result_d.status         = status_d;
      result_d.cursor_valid   = (cursor_d != NONE);
      result_d.cursor_account = (cursor_d != NONE) ? cur_acct_d : '0;
      result_d.entry_total    = TotalW'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= NONE;
      tail_q     <= NONE;
      cursor_q   <= NONE;
      count_q    <= '0;
      in_use_q   <= '0;
      free_q     <= '0;
      cur_acct_q <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      cursor_q   <= cursor_d;
      count_q    <= count_d;
      in_use_q   <= in_use_d;
      free_q     <= free_d;
      cur_acct_q <= cur_acct_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
    result_q <= result_d;
  end

  // Link memories: read at the cursor on accept, written during execute
  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (accept) begin
      next_rd_q <= next_mem[cursor_q[SW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (accept) begin
      prev_rd_q <= prev_mem[cursor_q[SW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acct_we) begin
      acct_mem[acct_waddr] <= cmd_q.account;
    end
    if (acct_re) begin
      acct_rd_q <= acct_mem[acct_raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/clm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clm_checker
// Port-level checks on the cursor linked list manager, bound to the top level.
// ----------------------------------------------------------------------------
module clm_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  start,
  input wire                  busy,
  input wire                  done_o,
  input clm_pkg::clm_result_t result_o
);

  import clm_pkg::*;

  localparam logic [TotalW-1:0] FULL_TOTAL = TotalW'(CAPACITY);

  // a taken command keeps the block busy for the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("command accepted but block not busy next cycle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobed while busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobed on consecutive cycles");

  a_no_cursor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.cursor_valid) |->
      (result_o.cursor_account == '0 && result_o.entry_total == '0))
    else $error("empty cursor with account or entries reported");

  a_full_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == STATUS_FULL) |->
      (result_o.entry_total == FULL_TOTAL && result_o.cursor_valid))
    else $error("full reported with pool not full");

endmodule

bind cursor_linked_list_manager_unit clm_checker #(.CAPACITY(CAPACITY)) u_clm_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
`default_nettype wire

FILE: tb/cursor_linked_list_manager_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_linked_list_manager_unit_test
// Self-checking bench for the cursor linked list manager. A directed table
// covers the empty and full list, the list ends and unused opcodes. Random
// commands follow in phases that alternately grow and shrink the list. Every
// result is checked field by field against the table's expectation where a row gives one, else a shadow slot pool.
// ----------------------------------------------------------------------------
module cursor_linked_list_manager_unit_test;
  import clm_pkg::*;

  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned QUIET_TAIL   = 100;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  localparam logic [4:0]       NO_SLOT         = 5'(CAPACITY);
  localparam logic [AcctW-1:0] ACCT_MAX        = '1;
  localparam logic [OpW-1:0]   OP_UNUSED_FIRST = 3'd5;
  localparam logic [OpW-1:0]   OP_UNUSED_LAST  = 3'd7;

  typedef struct {
    clm_cmd_t    cmd;
    bit          typed;
    clm_result_t res;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  clm_cmd_t    cmd_i;
  logic        done_o;
  clm_result_t result_o;

  cursor_linked_list_manager_unit #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // Shadow copy of the slot pool; the extra entry stands for no slot and is never read
  logic [AcctW-1:0] slot_acct [CAPACITY+1];
  logic [4:0]       next_slot [CAPACITY+1];
  logic [4:0]       prev_slot [CAPACITY+1];
  logic             slot_used [CAPACITY+1];
  logic [4:0]       head_q, tail_q, cursor_q;
  logic [TotalW-1:0] entries_q;

  clm_result_t cursor_reports[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          quiet;

  always #6 clk_i = ~clk_i;

  function automatic clm_result_t list_step(clm_cmd_t cmd);
    logic [4:0]  pick, prior, after, dest;
    clm_result_t res;
    res        = '0;
    res.status = STATUS_DONE;
    case (cmd.opcode)
      OP_APPEND: begin
        pick = NO_SLOT;
        for (int s = CAPACITY - 1; s >= 0; s--) begin
          if (!slot_used[s]) pick = 5'(s);
        end
        if (pick == NO_SLOT) begin
          res.status = STATUS_FULL;
        end else begin
          slot_used[pick] = 1'b1;
          slot_acct[pick] = cmd.account;
          next_slot[pick] = NO_SLOT;
          prev_slot[pick] = tail_q;
          if (tail_q != NO_SLOT) next_slot[tail_q] = pick;
          else head_q = pick;
          tail_q    = pick;
          cursor_q  = pick;
          entries_q = entries_q + 1'b1;
        end
      end
      OP_DELETE: begin
        if (cursor_q == NO_SLOT) begin
          res.status = STATUS_EMPTY;
        end else begin
          prior = prev_slot[cursor_q];
          after = next_slot[cursor_q];
          if (prior != NO_SLOT) next_slot[prior] = after;
          else head_q = after;
          if (after != NO_SLOT) prev_slot[after] = prior;
          else tail_q = prior;
          slot_used[cursor_q] = 1'b0;
          cursor_q  = (after != NO_SLOT) ? after : prior;
          entries_q = entries_q - 1'b1;
        end
      end
      OP_BACK, OP_FORWARD: begin
        if (cursor_q == NO_SLOT) begin
          res.status = STATUS_EMPTY;
        end else begin
          dest = (cmd.opcode == OP_FORWARD) ? next_slot[cursor_q] : prev_slot[cursor_q];
          if (dest != NO_SLOT) cursor_q = dest;
        end
      end
      default: ;
    endcase
    if (cursor_q != NO_SLOT) begin
      res.cursor_valid   = 1'b1;
      res.cursor_account = slot_acct[cursor_q];
    end
    res.entry_total = entries_q;
    return res;
  endfunction

  function automatic clm_result_t mk_res(logic [StatusW-1:0] status, logic valid,
                                         logic [AcctW-1:0] acct, int unsigned total);
    clm_result_t res;
    res.status         = status;
    res.cursor_valid   = valid;
    res.cursor_account = acct;
    res.entry_total    = TotalW'(total);
    return res;
  endfunction

  task automatic add_row(logic [OpW-1:0] op, logic [AcctW-1:0] acct, bit typed,
                         clm_result_t res);
    stim_row_t row;
    row.cmd.opcode  = op;
    row.cmd.account = acct;
    row.typed       = typed;
    row.res         = res;
    directed_rows.push_back(row);
  endtask

  // Drive one item and hold it until taken; the expectation is queued on accept
  task automatic issue_cmd(clm_cmd_t cmd, bit typed, clm_result_t typed_res);
    int unsigned gap;
    clm_result_t predicted;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= cmd;
    do @(posedge clk_i); while (busy);
    predicted = list_step(cmd);
    cursor_reports.push_back(typed ? typed_res : predicted);
  endtask

  task automatic drain_reports();
    start <= 1'b0;
    do @(posedge clk_i); while (cursor_reports.size() != 0);
  endtask

  function automatic clm_cmd_t random_cmd(int unsigned append_pct);
    clm_cmd_t    cmd;
    int unsigned r;
    cmd.account = AcctW'($urandom());
    r = $urandom_range(0, 19);
    if (r == 0) cmd.account = '0;
    else if (r == 1) cmd.account = ACCT_MAX;
    if ($urandom_range(0, 99) < append_pct) begin
      cmd.opcode = OP_APPEND;
    end else begin
      r = $urandom_range(0, 9);
      if (r < 4) cmd.opcode = OP_DELETE;
      else if (r < 6) cmd.opcode = OP_BACK;
      else if (r < 8) cmd.opcode = OP_FORWARD;
      else if (r == 8) cmd.opcode = OP_PEEK;
      else cmd.opcode = OpW'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    end
    return cmd;
  endfunction

  task automatic check_field(string name, logic [AcctW-1:0] exp_v, logic [AcctW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    clm_result_t exp_res;
    if (rst_ni && done_o) begin
      if (cursor_reports.size() == 0) begin
        $display("%0t: unexpected result: expected none, got 0x%0h", $time, result_o);
        mismatches++;
      end else begin
        exp_res = cursor_reports.pop_front();
        check_field("status", AcctW'(exp_res.status), AcctW'(result_o.status));
        check_field("cursor_valid", AcctW'(exp_res.cursor_valid),
                    AcctW'(result_o.cursor_valid));
        check_field("cursor_account", exp_res.cursor_account, result_o.cursor_account);
        check_field("entry_total", AcctW'(exp_res.entry_total), AcctW'(result_o.entry_total));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    clm_cmd_t    cmd;
    int unsigned append_pct;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd_i       = '0;
    mismatches  = 0;
    cycle_count = 0;
    quiet       = 1'b0;
    for (int s = 0; s < CAPACITY + 1; s++) begin
      slot_used[s] = 1'b0;
      slot_acct[s] = '0;
      next_slot[s] = NO_SLOT;
      prev_slot[s] = NO_SLOT;
    end
    head_q    = NO_SLOT;
    tail_q    = NO_SLOT;
    cursor_q  = NO_SLOT;
    entries_q = '0;

    // Empty list, unused opcode, single entry, list ends, then fill the pool past full
    add_row(OP_DELETE, ACCT_MAX, 1, mk_res(STATUS_EMPTY, 0, '0, 0));
    add_row(OP_BACK, '0, 1, mk_res(STATUS_EMPTY, 0, '0, 0));
    add_row(OP_FORWARD, ACCT_MAX, 1, mk_res(STATUS_EMPTY, 0, '0, 0));
    add_row(OP_UNUSED_LAST, '0, 1, mk_res(STATUS_DONE, 0, '0, 0));
    add_row(OP_APPEND, 31'h1234_5678, 1, mk_res(STATUS_DONE, 1, 31'h1234_5678, 1));
    add_row(OP_DELETE, '0, 1, mk_res(STATUS_DONE, 0, '0, 0));
    add_row(OP_APPEND, '0, 1, mk_res(STATUS_DONE, 1, '0, 1));
    add_row(OP_APPEND, ACCT_MAX, 1, mk_res(STATUS_DONE, 1, ACCT_MAX, 2));
    add_row(OP_BACK, '0, 1, mk_res(STATUS_DONE, 1, '0, 2));
    add_row(OP_BACK, ACCT_MAX, 1, mk_res(STATUS_DONE, 1, '0, 2));
    add_row(OP_FORWARD, '0, 1, mk_res(STATUS_DONE, 1, ACCT_MAX, 2));
    add_row(OP_FORWARD, '0, 1, mk_res(STATUS_DONE, 1, ACCT_MAX, 2));
    add_row(OP_DELETE, '0, 1, mk_res(STATUS_DONE, 1, '0, 1));
    add_row(OP_APPEND, ACCT_MAX, 1, mk_res(STATUS_DONE, 1, ACCT_MAX, 2));
    for (int i = 0; i < CAPACITY - 2; i++) begin
      add_row(OP_APPEND, (i % 2) ? 31'h2AAA_AAAA : 31'h5555_5555 ^ AcctW'(i), 0, '0);
    end
    add_row(OP_APPEND, 31'h0BAD_F00D, 0, '0);
    add_row(OP_PEEK, '0, 0, '0);
    add_row(OP_UNUSED_FIRST, ACCT_MAX, 0, '0);
    add_row(OP_BACK, '0, 0, '0);
    add_row(OP_DELETE, '0, 0, '0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      issue_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].res);
    end
    drain_reports();

    append_pct = 70;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      // alternate growing and shrinking phases so both ends of the pool are reached
      if (n % 60 == 0) append_pct = (append_pct == 70) ? 25 : 70;
      if (n % 90 == 0) quiet = ($urandom_range(0, 2) == 0);
      if (n >= RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
      if (n == RANDOM_ITEMS / 2) drain_reports();
      cmd = random_cmd(append_pct);
      issue_cmd(cmd, 0, '0);
    end

    start <= 1'b0;
    do @(posedge clk_i); while (cursor_reports.size() != 0);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
